### sv/gbs_pkg.sv
// Shared types and constants of the greedy box suppression block.
// Depends on nothing; imported by the cell, the overlap test unit and the top level.
`default_nettype none

package gbs_pkg;

  localparam int COORD_BITS = 16;
  localparam int EDGE_BITS  = COORD_BITS + 1;
  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int UNI_BITS   = AREA_BITS + 1;
  localparam int THR_BITS   = 8;
  localparam int PROD_BITS  = UNI_BITS + THR_BITS;
  localparam int ORD_BITS   = 16;
  localparam int KEPT_DEPTH = 64;
  localparam int CNT_BITS   = $clog2(KEPT_DEPTH + 1);

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(115);

  // one kept box: corners and area
  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [EDGE_BITS-1:0]  x1;
    logic [EDGE_BITS-1:0]  y1;
    logic [AREA_BITS-1:0]  area;
  } entry_t;

  // per-cell controls from the sequencer
  typedef struct packed {
    logic shift;
    logic wrap;
    logic load;
  } cell_ctl_t;

  // status of the overlap test pipeline
  typedef struct packed {
    logic hit_vld;
    logic hit;
    logic busy;
  } iou_stat_t;

endpackage

`default_nettype wire

### sv/gbs_cell.sv
// One storage cell of the kept-box ring.
// Depends on gbs_pkg; instantiated in a row by greedy_box_suppression_unit.
`default_nettype none

module gbs_cell
  import gbs_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    head_ent,
  input  wire entry_t    next_ent,
  input  wire entry_t    new_ent,
  output entry_t         ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  // load a survivor, or advance the ring: the last used cell takes the head
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.load) begin
      ent_nxt = new_ent;
    end else if (ctl.shift) begin
      ent_nxt = ctl.wrap ? head_ent : next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

### sv/gbs_iou.sv
// Five-stage pipelined overlap test: inter*256 > thr*union for one box pair a cycle.
// Depends on gbs_pkg; instantiated by greedy_box_suppression_unit.
`default_nettype none

module gbs_iou
  import gbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 issue,
  input  wire entry_t               cur,
  input  wire logic [AREA_BITS-1:0] cur_area,
  input  wire entry_t               kept,
  input  wire logic [THR_BITS-1:0]  thr,
  output iou_stat_t                 stat
);

  logic                  v1_r, v2_r, v3_r, v4_r, hv_r;
  logic [COORD_BITS-1:0] dx_r, dy_r;
  logic [AREA_BITS-1:0]  karea_r;
  logic [AREA_BITS-1:0]  inter2_r, inter3_r;
  logic [UNI_BITS-1:0]   sum_r, uni_r;
  logic [PROD_BITS-1:0]  prod_r;
  logic [PROD_BITS-1:0]  lhs_r;
  logic                  hit_r;

  logic [EDGE_BITS-1:0]  lx, ly, rx, ry;
  logic [COORD_BITS-1:0] dx_nxt, dy_nxt;

  // clamp the overlap extent to zero when disjoint or touching
  always_comb begin
    lx = (cur.x0 > kept.x0) ? EDGE_BITS'(cur.x0) : EDGE_BITS'(kept.x0);
    ly = (cur.y0 > kept.y0) ? EDGE_BITS'(cur.y0) : EDGE_BITS'(kept.y0);
    rx = (cur.x1 < kept.x1) ? cur.x1 : kept.x1;
    ry = (cur.y1 < kept.y1) ? cur.y1 : kept.y1;
    dx_nxt = (rx > lx) ? COORD_BITS'(rx - lx) : '0;
    dy_nxt = (ry > ly) ? COORD_BITS'(ry - ly) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      hv_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      hv_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    karea_r  <= kept.area;
    inter2_r <= AREA_BITS'(dx_r * dy_r);
    sum_r    <= UNI_BITS'(cur_area) + UNI_BITS'(karea_r);
    inter3_r <= inter2_r;
    uni_r    <= sum_r - UNI_BITS'(inter2_r);
    prod_r   <= PROD_BITS'(thr * uni_r);
    lhs_r    <= {1'b0, inter3_r, 8'h00};
    hit_r    <= lhs_r > prod_r;
  end

  assign stat.hit_vld = hv_r;
  assign stat.hit     = hit_r;
  assign stat.busy    = v1_r | v2_r | v3_r | v4_r | hv_r;

endmodule

`default_nettype wire

### sv/greedy_box_suppression_unit.sv
// Top level of the greedy box suppression block: sequencer, kept-box ring, threshold.
// Depends on gbs_pkg, gbs_cell and gbs_iou.
`default_nettype none

// Greedy, class-agnostic non-maximum suppression. Present boxes in descending
// score order, one request per start pulse while busy is low; in_frame_start on
// the first box of a frame empties the kept store and restarts the ordinal.
// With K (1..64) boxes kept so far in the frame, a request passes each of the K
// kept boxes through the test: they sit in a ring of 64 cells that rotates one
// place a cycle past a single five-stage overlap test, so every kept box is met
// once; the sequencer then ends the scan, drains the test and presents the
// result. With the store empty the test is skipped. busy drops in the cycle the
// result is presented, so the next request can be accepted at the edge that
// ends it; a new request is never taken while the last one is still in the
// scan or in the overlap test, since busy stays high until its result is out.
// The result appears on out_keep, out_box_ordinal and out_store_overflow for
// exactly one cycle with out_valid; the receiver cannot stall it, so sample it
// on that cycle. A box that survives while the store is full reports keep with
// store_overflow set and is not stored. Write the threshold (fraction of 256,
// strict compare) on the cfg channel only while busy is low; cfg_ready is
// always high.
module greedy_box_suppression_unit
  import gbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_frame_start,
  input  wire logic [COORD_BITS-1:0] in_left_x,
  input  wire logic [COORD_BITS-1:0] in_top_y,
  input  wire logic [COORD_BITS-1:0] in_box_width,
  input  wire logic [COORD_BITS-1:0] in_box_height,
  // result channel
  output logic                       out_valid,
  output logic                       out_keep,
  output logic [ORD_BITS-1:0]        out_box_ordinal,
  output logic                       out_store_overflow,
  // threshold register
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [THR_BITS-1:0]   cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [THR_BITS-1:0]   thr_r;
  logic [CNT_BITS-1:0]   kept_cnt_r, kept_cnt_nxt;
  logic [CNT_BITS-1:0]   step_r, step_nxt;
  logic [ORD_BITS-1:0]   box_cnt_r, box_cnt_nxt;
  logic [ORD_BITS-1:0]   ord_r, ord_nxt;
  logic                  hit_r, hit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_keep_r, out_keep_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic [COORD_BITS-1:0] cur_w_r, cur_h_r;
  entry_t                cur_r;
  entry_t                new_ent;

  logic                  accept;
  logic                  issue;
  logic                  append;
  logic                  store_full;
  iou_stat_t             iou_stat;

  entry_t                ents [KEPT_DEPTH];
  cell_ctl_t             ctls [KEPT_DEPTH];

  assign accept     = start && !busy;
  assign busy       = state_r != ST_IDLE;
  assign cfg_ready  = 1'b1;
  assign issue      = (state_r == ST_SCAN) && (step_r < kept_cnt_r);
  assign store_full = kept_cnt_r == CNT_BITS'(KEPT_DEPTH);

  // sequencer: capture, rotate the ring once past the test, drain, report
  always_comb begin
    state_nxt     = state_r;
    kept_cnt_nxt  = kept_cnt_r;
    step_nxt      = step_r;
    box_cnt_nxt   = box_cnt_r;
    ord_nxt       = ord_r;
    hit_nxt       = hit_r | (iou_stat.hit_vld & iou_stat.hit);
    out_valid_nxt = 1'b0;
    out_keep_nxt  = out_keep_r;
    out_ovf_nxt   = out_ovf_r;
    append        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hit_nxt  = 1'b0;
          step_nxt = '0;
          if (in_frame_start) begin
            kept_cnt_nxt = '0;
            ord_nxt      = '0;
            box_cnt_nxt  = ORD_BITS'(1);
          end else begin
            ord_nxt     = box_cnt_r;
            box_cnt_nxt = box_cnt_r + ORD_BITS'(1);
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          step_nxt = step_r + CNT_BITS'(1);
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // every hit has been folded in once the pipe is empty
        if (!iou_stat.busy) begin
          out_valid_nxt = 1'b1;
          out_keep_nxt  = !hit_r;
          out_ovf_nxt   = !hit_r && store_full;
          append        = !hit_r && !store_full;
          if (append) begin
            kept_cnt_nxt = kept_cnt_r + CNT_BITS'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THR_RESET;
      kept_cnt_r  <= '0;
      step_r      <= '0;
      box_cnt_r   <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_cnt_r  <= kept_cnt_nxt;
      step_r      <= step_nxt;
      box_cnt_r   <= box_cnt_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  // payload: hold the request's box, area ready before the first pair reaches it
  always_ff @(posedge clk) begin
    ord_r      <= ord_nxt;
    out_keep_r <= out_keep_nxt;
    out_ovf_r  <= out_ovf_nxt;
    cur_r.area <= AREA_BITS'(cur_w_r * cur_h_r);
    if (accept) begin
      cur_w_r  <= in_box_width;
      cur_h_r  <= in_box_height;
      cur_r.x0 <= in_left_x;
      cur_r.y0 <= in_top_y;
      cur_r.x1 <= EDGE_BITS'(in_left_x) + EDGE_BITS'(in_box_width);
      cur_r.y1 <= EDGE_BITS'(in_top_y) + EDGE_BITS'(in_box_height);
    end
  end

  assign new_ent = cur_r;

  // kept-box ring: the used cells rotate toward cell 0, the last used wraps
  for (genvar i = 0; i < KEPT_DEPTH; i++) begin : g_cell
    assign ctls[i].shift = issue;
    assign ctls[i].wrap  = kept_cnt_r == CNT_BITS'(i + 1);
    assign ctls[i].load  = append && (kept_cnt_r == CNT_BITS'(i));

    gbs_cell u_cell (
      .clk      (clk),
      .ctl      (ctls[i]),
      .head_ent (ents[0]),
      .next_ent (ents[(i + 1) % KEPT_DEPTH]),
      .new_ent  (new_ent),
      .ent      (ents[i])
    );
  end

  gbs_iou u_iou (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .cur      (cur_r),
    .cur_area (cur_r.area),
    .kept     (ents[0]),
    .thr      (thr_r),
    .stat     (iou_stat)
  );

  assign out_valid          = out_valid_r;
  assign out_keep           = out_keep_r;
  assign out_box_ordinal    = ord_r;
  assign out_store_overflow = out_ovf_r;

endmodule

`default_nettype wire
